FILE: src/text_message_segment_deframer_unit_assert.svh
// Assertion macros used by the deframer controller.
`ifndef TEXT_MESSAGE_SEGMENT_DEFRAMER_UNIT_ASSERT_SVH
`define TEXT_MESSAGE_SEGMENT_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TMSD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmsd same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TMSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tmsd next-cycle check failed");

`endif

FILE: src/tmsd_pkg.sv
// Shared constants and controller/datapath interface types of the deframer.
`default_nettype none
package tmsd_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int BYTE_WIDTH = 8;
   localparam int USER_WIDTH = 3;
   localparam int LEN_WIDTH = 5;
   localparam int BODY_DEPTH = 16;
   localparam int BODY_IDX_WIDTH = $clog2(BODY_DEPTH);
   localparam int CRC_WIDTH = 16;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'h1021;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_header;
      logic load_word;
      logic step_byte;
      logic out_clear;
      logic out_next;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sync_word;
      logic seg_done;
      logic crc_ok;
      logic out_last;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: src/text_message_segment_deframer_unit.sv
// Top level of the text message segment deframer.
//
//   channel  dir  payload                                       accepted when
//   req      in   tdata[31:0] word, earliest byte in [31:24]    req_tvalid & req_tready
//   rsp      out  tdata[7:0] text_byte, tuser[2:0], tlast       rsp_tvalid & rsp_tready
//
// A word is taken; a header or body word then steps through the byte-serial CRC
// unit one byte at a time, up to four bytes, before the next word is taken.
// A passing segment then delivers one body beat per cycle, 1 to 16 beats, while no
// input is taken. A rsp stall holds the current beat. Reset returns to sync search.
`default_nettype none
module text_message_segment_deframer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [tmsd_pkg::WORD_WIDTH-1:0]       req_tdata,  // [31:0] word
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [tmsd_pkg::BYTE_WIDTH-1:0]      rsp_tdata,  // [7:0] text_byte
   // [0] first_segment, [1] last_segment, [2] is_command
   output logic [tmsd_pkg::USER_WIDTH-1:0]      rsp_tuser,
   output logic                                 rsp_tlast   // end_of_run
);
   import tmsd_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   tmsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmsd_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: src/tmsd_datapath.sv
// Datapath of the deframer: byte shifter, running CRC, body store and output select.
`default_nettype none
module tmsd_datapath (
   input  wire                                  clock,
   input  wire tmsd_pkg::ctl_cmd_type           cmd,
   output tmsd_pkg::dp_status_type              status,
   input  wire [tmsd_pkg::WORD_WIDTH-1:0]       req_tdata,
   output logic [tmsd_pkg::BYTE_WIDTH-1:0]      rsp_tdata,
   output logic [tmsd_pkg::USER_WIDTH-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);
   import tmsd_pkg::*;

   logic [WORD_WIDTH-1:0]     word_ff, word_in;
   logic [CRC_WIDTH-1:0]      crc_ff, crc_in;
   logic [LEN_WIDTH-1:0]      held_ff, held_in;
   logic [LEN_WIDTH-1:0]      body_len_ff, body_len_in;
   logic [USER_WIDTH-1:0]     flags_ff, flags_in;
   logic [BODY_IDX_WIDTH-1:0] out_idx_ff, out_idx_in;
   logic [BYTE_WIDTH-1:0]     body_ff [BODY_DEPTH];

   logic [LEN_WIDTH-1:0]      need;
   logic [LEN_WIDTH-1:0]      held_plus2;
   logic [LEN_WIDTH-1:0]      body_len_m1;
   logic [LEN_WIDTH-1:0]      body_pos;
   logic [BYTE_WIDTH-1:0]     cur_byte;
   logic [BYTE_WIDTH-1:0]     crc_byte_val;
   logic [CRC_WIDTH-1:0]      crc_next;
   logic                      body_write;

   // MSB-first CRC update over one byte.
   function automatic logic [CRC_WIDTH-1:0] crc_byte(input logic [CRC_WIDTH-1:0] r,
                                                     input logic [BYTE_WIDTH-1:0] b);
      logic [CRC_WIDTH-1:0] c;
      logic fb;
      c = r;
      for (int k = BYTE_WIDTH - 1; k >= 0; k--) begin
         fb = c[CRC_WIDTH-1] ^ b[k];
         c = {c[CRC_WIDTH-2:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   always_comb begin
      need = body_len_ff + LEN_WIDTH'(4);
      held_plus2 = held_ff + LEN_WIDTH'(2);
      body_len_m1 = body_len_ff - LEN_WIDTH'(1);
      body_pos = held_ff - LEN_WIDTH'(2);
      cur_byte = word_ff[WORD_WIDTH-1 -: BYTE_WIDTH];
      // The two check bytes at the end of the segment enter the CRC inverted.
      crc_byte_val = (held_plus2 >= need) ? ~cur_byte : cur_byte;
      crc_next = crc_byte(crc_ff, crc_byte_val);
      body_write = cmd.step_byte && (held_ff >= LEN_WIDTH'(2)) && (held_plus2 < need);

      status.sync_word = &req_tdata;
      status.seg_done = (held_ff + LEN_WIDTH'(1)) == need;
      status.crc_ok = (crc_next == '0);
      status.out_last = (out_idx_ff == body_len_m1[BODY_IDX_WIDTH-1:0]);

      word_in = word_ff;
      crc_in = crc_ff;
      held_in = held_ff;
      body_len_in = body_len_ff;
      flags_in = flags_ff;
      out_idx_in = out_idx_ff;

      if (cmd.load_header) begin
         word_in = req_tdata;
         crc_in = CRC_INIT;
         held_in = '0;
         // Header byte: bit 6 first, bit 5 last, bit 4 command, low nibble length.
         body_len_in = req_tdata[28] ? LEN_WIDTH'(BODY_DEPTH)
                                     : {1'b0, req_tdata[27:24]} + LEN_WIDTH'(1);
         flags_in = {req_tdata[28], req_tdata[29], req_tdata[30]};
      end else if (cmd.load_word) begin
         word_in = req_tdata;
      end else if (cmd.step_byte) begin
         word_in = {word_ff[WORD_WIDTH-BYTE_WIDTH-1:0], {BYTE_WIDTH{1'b0}}};
         crc_in = crc_next;
         held_in = held_ff + LEN_WIDTH'(1);
      end

      if (cmd.out_clear) begin
         out_idx_in = '0;
      end else if (cmd.out_next) begin
         out_idx_in = out_idx_ff + BODY_IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      crc_ff <= crc_in;
      held_ff <= held_in;
      body_len_ff <= body_len_in;
      flags_ff <= flags_in;
      out_idx_ff <= out_idx_in;
      if (body_write) begin
         body_ff[body_pos[BODY_IDX_WIDTH-1:0]] <= cur_byte;
      end
   end

   assign rsp_tdata = body_ff[out_idx_ff];
   assign rsp_tuser = flags_ff;
   assign rsp_tlast = status.out_last;

endmodule
`default_nettype wire

FILE: src/tmsd_ctrl.sv
// Controller of the deframer: sync/header/body phase and byte, check and emit sequencing.
`default_nettype none
`include "text_message_segment_deframer_unit_assert.svh"
module tmsd_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   input  wire tmsd_pkg::dp_status_type status,
   output tmsd_pkg::ctl_cmd_type      cmd
);
   import tmsd_pkg::*;

   typedef enum logic [1:0] {ST_IN, ST_BYTE, ST_EMIT} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY} phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] byte_cnt_ff, byte_cnt_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      byte_cnt_in = byte_cnt_ff;
      cmd = '0;
      case (state_ff)
         ST_IN: begin
            if (req_tvalid) begin
               byte_cnt_in = '0;
               case (phase_ff)
                  PH_IDLE: begin
                     if (status.sync_word) begin
                        phase_in = PH_HEADER;
                     end
                  end
                  PH_HEADER: begin
                     cmd.load_header = 1'b1;
                     phase_in = PH_BODY;
                     state_in = ST_BYTE;
                  end
                  PH_BODY: begin
                     cmd.load_word = 1'b1;
                     state_in = ST_BYTE;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         ST_BYTE: begin
            cmd.step_byte = 1'b1;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (status.seg_done) begin
               // Remaining bytes of this word are dropped; the next word is checked for sync.
               phase_in = PH_IDLE;
               cmd.out_clear = 1'b1;
               state_in = status.crc_ok ? ST_EMIT : ST_IN;
            end else if (byte_cnt_ff == 2'd3) begin
               state_in = ST_IN;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  state_in = ST_IN;
               end
            end
         end
         default: begin
            state_in = ST_IN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IN;
         phase_ff <= PH_IDLE;
         byte_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   assign req_tready = (state_ff == ST_IN);
   assign rsp_tvalid = (state_ff == ST_EMIT);

   `TMSD_ASSERT_SAME(a_no_overlap, req_tready, !rsp_tvalid)
   `TMSD_ASSERT_NEXT(a_pass_emits, (state_ff == ST_BYTE) && status.seg_done && status.crc_ok,
                     rsp_tvalid)
   `TMSD_ASSERT_NEXT(a_fail_drops, (state_ff == ST_BYTE) && status.seg_done && !status.crc_ok,
                     req_tready && (phase_ff == PH_IDLE))
   `TMSD_ASSERT_NEXT(a_last_beat_frees, rsp_tvalid && rsp_tready && status.out_last,
                     req_tready)

endmodule
`default_nettype wire

FILE: test/text_message_segment_deframer_unit_tb.sv
// Self-checking testbench for the deframer: streams sync, header and body words, checks beats.
module text_message_segment_deframer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int STORE_DEPTH = 20;
   localparam int TARGET_WORDS = 450;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_BEAT = 80;
   localparam int STEADY_FROM = 1500;
   localparam int STEADY_TO = 2700;
   localparam logic [31:0] SYNC_WORD = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {SEEK_SYNC, TAKE_HEADER, TAKE_BODY} deframe_phase_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} body_fill_type;

   typedef struct {
      logic [tmsd_pkg::WORD_WIDTH-1:0] word;
      bit                              wait_drain;
   } rx_word_type;

   typedef struct {
      logic [tmsd_pkg::BYTE_WIDTH-1:0] text_byte;
      logic                            first_seg;
      logic                            last_seg;
      logic                            command;
      logic                            run_end;
   } text_beat_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [tmsd_pkg::WORD_WIDTH-1:0]     req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [tmsd_pkg::BYTE_WIDTH-1:0]     rsp_tdata;
   logic [tmsd_pkg::USER_WIDTH-1:0]     rsp_tuser;
   logic                                rsp_tlast;

   rx_word_type    words_pending[$];
   text_beat_type  text_expected[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             beats_seen = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   // Predictor state.
   deframe_phase_type               seg_phase = SEEK_SYNC;
   logic [tmsd_pkg::LEN_WIDTH-1:0]  seg_len = '0;
   logic [tmsd_pkg::LEN_WIDTH-1:0]  seg_held = '0;
   logic [7:0]                      seg_store [STORE_DEPTH];

   text_message_segment_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[15] ^ b[k];
         r = {r[14:0], 1'b0};
         if (fb) r = r ^ tmsd_pkg::CRC_POLY;
      end
      return r;
   endfunction

   // Runs the CRC over the collected segment and queues its body beats if it passes.
   function void release_segment();
      logic [15:0]    crc;
      logic [7:0]     b;
      int             total;
      int             n;
      text_beat_type  beat;
      total = seg_held;
      crc = tmsd_pkg::CRC_INIT;
      for (int i = 0; i < total; i++) begin
         b = seg_store[i];
         if (i + 2 >= total) b = ~b;
         crc = crc16_step(crc, b);
      end
      if (crc == 16'h0000) begin
         n = total - 4;
         for (int i = 0; i < n; i++) begin
            beat.text_byte = seg_store[2 + i];
            beat.first_seg = seg_store[0][6];
            beat.last_seg = seg_store[0][5];
            beat.command = seg_store[0][4];
            beat.run_end = (i + 1 == n);
            text_expected.push_back(beat);
         end
      end
   endfunction

   function void deframe_word(input logic [tmsd_pkg::WORD_WIDTH-1:0] w);
      logic [7:0] b [4];
      int         need;
      bit         done;
      for (int i = 0; i < 4; i++) b[i] = w[31 - 8 * i -: 8];
      case (seg_phase)
         SEEK_SYNC: begin
            if (w == SYNC_WORD) seg_phase = TAKE_HEADER;
         end
         TAKE_HEADER: begin
            seg_len = b[0][4] ? 5'd16 : {1'b0, b[0][3:0]} + 5'd1;
            for (int i = 0; i < 4; i++) seg_store[i] = b[i];
            seg_held = 5'd4;
            seg_phase = TAKE_BODY;
         end
         TAKE_BODY: begin
            need = seg_len + 4;
            if (need > STORE_DEPTH) need = STORE_DEPTH;
            done = 1'b0;
            // Bytes past the segment end in the same word are dropped.
            for (int i = 0; i < 4; i++) begin
               if (!done) begin
                  if (seg_held < STORE_DEPTH) seg_store[seg_held] = b[i];
                  seg_held = seg_held + 5'd1;
                  if (seg_held >= need) begin
                     release_segment();
                     seg_phase = SEEK_SYNC;
                     seg_held = '0;
                     done = 1'b1;
                  end
               end
            end
         end
         default: seg_phase = SEEK_SYNC;
      endcase
   endfunction

   function void queue_word(input logic [31:0] w, input bit drain);
      rx_word_type item;
      item.word = w;
      item.wait_drain = drain;
      words_pending.push_back(item);
   endfunction

   // Queues a sync word and a framed segment with a matching CRC, optionally damaged.
   task automatic queue_segment(input logic [7:0] h0, input logic [7:0] h1,
                                input body_fill_type fill, input bit corrupt, input bit drain);
      logic [7:0]  seg [24];
      logic [15:0] crc;
      int          body_n;
      int          total;
      int          k;
      body_n = h0[4] ? 16 : int'(h0[3:0]) + 1;
      total = body_n + 4;
      seg[0] = h0;
      seg[1] = h1;
      for (int i = 2; i < body_n + 2; i++) begin
         case (fill)
            FILL_ZERO: seg[i] = 8'h00;
            FILL_ONES: seg[i] = 8'hFF;
            default:   seg[i] = 8'($urandom_range(255));
         endcase
      end
      crc = tmsd_pkg::CRC_INIT;
      for (int i = 0; i < body_n + 2; i++) crc = crc16_step(crc, seg[i]);
      seg[body_n + 2] = ~crc[15:8];
      seg[body_n + 3] = ~crc[7:0];
      for (int i = total; i < 24; i++) seg[i] = 8'($urandom_range(255));
      if (corrupt) begin
         k = $urandom_range(total - 1, 1);
         seg[k] = seg[k] ^ (8'h01 << $urandom_range(7));
      end
      queue_word(SYNC_WORD, drain);
      for (int i = 0; i < total; i += 4)
         queue_word({seg[i], seg[i + 1], seg[i + 2], seg[i + 3]}, 1'b0);
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s: expected %h, got %h (beat %0d)", what, want, got,
                     beats_seen);
      end
   endtask

   // Sender: holds a word until taken, then predicts it.
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_word(req_tdata);
            void'(words_pending.pop_front());
         end
         if (req_tvalid && !req_tready)
            offer = 1'b1;
         else
            offer = words_pending.size() != 0
                    && !(words_pending[0].wait_drain && text_expected.size() != 0)
                    && ((cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
                        || $urandom_range(99) >= 31);
         req_tvalid <= offer;
         if (offer) req_tdata <= words_pending[0].word;
      end
   end

   // Receiver: checks each beat and drives ready with random stalls and one long hold.
   always @(posedge clock) begin
      text_beat_type want;
      bit            take;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (text_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected beat: data %h user %b last %b", rsp_tdata, rsp_tuser,
                           rsp_tlast);
            end else begin
               want = text_expected.pop_front();
               check_field("text_byte", want.text_byte, rsp_tdata);
               check_field("first_segment", 8'(want.first_seg), 8'(rsp_tuser[0]));
               check_field("last_segment", 8'(want.last_seg), 8'(rsp_tuser[1]));
               check_field("is_command", 8'(want.command), 8'(rsp_tuser[2]));
               check_field("end_of_run", 8'(want.run_end), 8'(rsp_tlast));
            end
         end
         if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            take = (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
                   || $urandom_range(99) >= 31;
         end
         rsp_tready <= take;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** text_message_segment_deframer_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int meaningful;
      int pick;
      int burst;

      // Idle noise, including a near-sync word.
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hFFFF_FFFE, 1'b0);
      // Shortest body, no flags, zero bytes; trailing bytes of the last word are padding.
      queue_segment(8'h00, 8'h00, FILL_ZERO, 1'b0, 1'b0);
      // Longest plain body with first and last flags, all-ones bytes.
      queue_segment(8'h6F, 8'hFF, FILL_ONES, 1'b0, 1'b0);
      // A header word of four 0xFF bytes right after sync.
      queue_segment(8'hFF, 8'hFF, FILL_ONES, 1'b0, 1'b0);
      // Command bit overrides the length nibble.
      queue_segment(8'h13, 8'h5A, FILL_RANDOM, 1'b0, 1'b0);
      // Damaged CRC: dropped without beats.
      queue_segment(8'h43, 8'h21, FILL_RANDOM, 1'b1, 1'b0);

      meaningful = 0;
      while (meaningful < TARGET_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            queue_word($urandom(), 1'b0);
         end else if (pick < 18) begin
            // Sync followed by arbitrary words.
            queue_word(SYNC_WORD, 1'b0);
            burst = $urandom_range(5, 1);
            for (int i = 0; i < burst; i++) queue_word($urandom(), 1'b0);
            meaningful += burst + 1;
         end else begin
            burst = words_pending.size();
            queue_segment(8'($urandom_range(255)), 8'($urandom_range(255)),
                          ($urandom_range(19) == 0) ? FILL_ZERO
                          : ($urandom_range(19) == 0) ? FILL_ONES : FILL_RANDOM,
                          $urandom_range(9) == 0,
                          meaningful == 0 || $urandom_range(49) == 0);
            meaningful += words_pending.size() - burst;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (words_pending.size() != 0 || req_tvalid) @(posedge clock);
      while (text_expected.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (error_count == 0 && text_expected.size() == 0)
         $display("** text_message_segment_deframer_unit: PASSED **");
      else
         $display("** text_message_segment_deframer_unit: FAILED **");
      $finish;
   end

endmodule
